[rtl/bf3_pkg.sv]
// box filter package: widths, register indexes, payload and stage structs
// no dependencies; every other file but bf3_ram refers to it by scoped names
`timescale 1ns / 1ps

package bf3_pkg;

    // line store depth and the widths that follow from it
    localparam int MAX_LINE = 1024;
    localparam int COL_W    = $clog2(MAX_LINE);
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;
    localparam int ROW_W    = 12;
    localparam int PIX_W    = 8;
    localparam int SUM_W    = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = HEIGHT_W;

    localparam int MIN_DIM    = 3;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(512);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(512);

    // floor(sum / 9) == (sum * 7282) >> 16 for every sum up to 9 * 255
    localparam int RECIP_W    = 13;
    localparam int DIV9_SHIFT = 16;
    localparam logic [RECIP_W-1:0] DIV9_RECIP = RECIP_W'(7282);
    localparam int PROD_W     = SUM_W + RECIP_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             start_of_frame;
    } pix_req_t;

    typedef struct packed {
        logic [PIX_W-1:0] mean_pixel;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             last_of_frame;
    } res_req_t;

    // position information that rides along with a pixel
    typedef struct packed {
        logic             emit;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } tag_t;

    // stage after the line store read
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] idx;
        logic             fwd;
        tag_t             tag;
    } s1_t;

    // stage after the neighborhood sum
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        tag_t             tag;
    } s2_t;

endpackage

[rtl/bf3_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bf3_scan.sv]
// configuration registers, raster position counters and the first pipeline stage
// depends on bf3_pkg
`timescale 1ns / 1ps

module bf3_scan (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [bf3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bf3_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           adv,
    input  logic                           accept,
    input  bf3_pkg::pix_req_t              pix_req,
    output logic [bf3_pkg::COL_W-1:0]      rd_addr,
    output logic                           s1_valid,
    output bf3_pkg::s1_t                   s1
);

    logic [bf3_pkg::WIDTH_W-1:0]  width_reg;
    logic [bf3_pkg::HEIGHT_W-1:0] height_reg;
    logic [bf3_pkg::COL_W-1:0]    col_reg, col_next;
    logic [bf3_pkg::ROW_W-1:0]    row_reg, row_next;
    logic                         s1_valid_reg;
    bf3_pkg::s1_t                 s1_reg, s1_next;

    logic [bf3_pkg::WIDTH_W-1:0]  w_eff;
    logic [bf3_pkg::HEIGHT_W-1:0] h_eff;
    logic [bf3_pkg::COL_W-1:0]    col_cur;
    logic [bf3_pkg::ROW_W-1:0]    row_cur;
    logic [bf3_pkg::WIDTH_W-1:0]  col_inc;
    logic [bf3_pkg::HEIGHT_W-1:0] row_inc;

    always_comb
    begin
        priority if (width_reg < bf3_pkg::WIDTH_W'(bf3_pkg::MIN_DIM))
            w_eff = bf3_pkg::WIDTH_W'(bf3_pkg::MIN_DIM);
        else if (width_reg > bf3_pkg::WIDTH_W'(bf3_pkg::MAX_LINE))
            w_eff = bf3_pkg::WIDTH_W'(bf3_pkg::MAX_LINE);
        else
            w_eff = width_reg;

        priority if (height_reg < bf3_pkg::HEIGHT_W'(bf3_pkg::MIN_DIM))
            h_eff = bf3_pkg::HEIGHT_W'(bf3_pkg::MIN_DIM);
        else if (height_reg > bf3_pkg::HEIGHT_W'(bf3_pkg::MAX_HEIGHT))
            h_eff = bf3_pkg::HEIGHT_W'(bf3_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // start of frame zeroes the position before this pixel is placed
    assign col_cur = pix_req.start_of_frame ? '0 : col_reg;
    assign row_cur = pix_req.start_of_frame ? '0 : row_reg;
    assign col_inc = {1'b0, col_cur} + bf3_pkg::WIDTH_W'(1);
    assign row_inc = {1'b0, row_cur} + bf3_pkg::HEIGHT_W'(1);
    assign rd_addr = col_cur;

    always_comb
    begin
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : row_inc[bf3_pkg::ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[bf3_pkg::COL_W-1:0];
            row_next = row_cur;
        end

        s1_next.pixel    = pix_req.pixel_in;
        s1_next.idx      = col_cur;
        // the item ahead writes this same entry at this edge, so take its data
        s1_next.fwd      = s1_valid_reg && (col_cur == s1_reg.idx);
        s1_next.tag.emit = (row_cur >= bf3_pkg::ROW_W'(2)) && (col_cur >= bf3_pkg::COL_W'(2));
        s1_next.tag.last = ({1'b0, row_cur} == h_eff - bf3_pkg::HEIGHT_W'(1))
                        && ({1'b0, col_cur} == w_eff - bf3_pkg::WIDTH_W'(1));
        s1_next.tag.row  = row_cur - bf3_pkg::ROW_W'(1);
        s1_next.tag.col  = col_cur - bf3_pkg::COL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bf3_pkg::WIDTH_RESET;
            height_reg <= bf3_pkg::HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bf3_pkg::REG_LINE_WIDTH:   width_reg  <= cfg_data[bf3_pkg::WIDTH_W-1:0];
                bf3_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (adv)
            begin
                s1_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

endmodule

[rtl/bf3_window.sv]
// 3x3 window columns, line store bypass and the nine pixel sum stage
// depends on bf3_pkg
`timescale 1ns / 1ps

module bf3_window (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      s1_valid,
    input  bf3_pkg::s1_t              s1,
    input  logic [bf3_pkg::PIX_W-1:0] older_rd,
    input  logic [bf3_pkg::PIX_W-1:0] newer_rd,
    output logic [bf3_pkg::PIX_W-1:0] older_wr,
    output logic                      s2_valid,
    output bf3_pkg::s2_t              s2
);

    logic [bf3_pkg::PIX_W-1:0] win_reg [6];
    logic [bf3_pkg::PIX_W-1:0] fwd_top_reg, fwd_mid_reg;
    logic                      s2_valid_reg;
    bf3_pkg::s2_t              s2_reg, s2_next;
    logic [bf3_pkg::PIX_W-1:0] top, mid;
    logic                      step;

    assign step = adv && s1_valid;
    assign top  = s1.fwd ? fwd_top_reg : older_rd;
    assign mid  = s1.fwd ? fwd_mid_reg : newer_rd;
    assign older_wr = mid;

    always_comb
    begin
        s2_next.sum = bf3_pkg::SUM_W'(top) + bf3_pkg::SUM_W'(mid) + bf3_pkg::SUM_W'(s1.pixel)
                    + bf3_pkg::SUM_W'(win_reg[0]) + bf3_pkg::SUM_W'(win_reg[1])
                    + bf3_pkg::SUM_W'(win_reg[2]) + bf3_pkg::SUM_W'(win_reg[3])
                    + bf3_pkg::SUM_W'(win_reg[4]) + bf3_pkg::SUM_W'(win_reg[5]);
        s2_next.tag = s1.tag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 6; k++)
            begin
                win_reg[k] <= '0;
            end
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top;
                win_reg[4] <= mid;
                win_reg[5] <= s1.pixel;
            end
            if (adv)
            begin
                s2_valid_reg <= s1_valid;
            end
        end
    end

    // what this item leaves in the line stores, for a follower at the same column
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            fwd_top_reg <= mid;
            fwd_mid_reg <= s1.pixel;
            s2_reg      <= s2_next;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2       = s2_reg;

endmodule

[rtl/bf3_mean.sv]
// divide by nine through a reciprocal multiply, and the result register
// depends on bf3_pkg
`timescale 1ns / 1ps

module bf3_mean (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               s2_valid,
    input  bf3_pkg::s2_t       s2,
    output logic               res_valid,
    output bf3_pkg::res_req_t  res_req
);

    logic [bf3_pkg::PROD_W-1:0] prod;
    logic                       res_valid_reg;
    bf3_pkg::res_req_t          res_reg, res_next;

    assign prod = bf3_pkg::PROD_W'(s2.sum) * bf3_pkg::PROD_W'(bf3_pkg::DIV9_RECIP);

    always_comb
    begin
        res_next.mean_pixel    = prod[bf3_pkg::DIV9_SHIFT +: bf3_pkg::PIX_W];
        res_next.out_row       = s2.tag.row;
        res_next.out_col       = s2.tag.col;
        res_next.last_of_frame = s2.tag.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= s2_valid && s2.tag.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_req   = res_reg;

endmodule

[rtl/box_filter_3x3.sv]
// a result passes the first stage, the sum stage and the result register after its pixel request is accepted
// throughput: one pixel per cycle while no result stalls; two line store rams read on accept, written as it leaves s1
// a stalled result freezes the whole pipeline, and pix_stall is high in that cycle
// reset: position counters and window to zero, line_width and frame_height to 512
// the line stores are not cleared; pixels of the first two rows fill them
`timescale 1ns / 1ps

module box_filter_3x3 (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [bf3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bf3_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           pix_valid,
    output logic                           pix_stall,
    input  bf3_pkg::pix_req_t              pix_req,
    output logic                           res_valid,
    input  logic                           res_stall,
    output bf3_pkg::res_req_t              res_req
);

    logic                          adv;
    logic                          accept;
    logic [bf3_pkg::COL_W-1:0]     rd_addr;
    logic                          s1_valid;
    bf3_pkg::s1_t                  s1;
    logic [bf3_pkg::PIX_W-1:0]     older_rd, newer_rd, older_wr;
    logic                          s2_valid;
    bf3_pkg::s2_t                  s2;
    logic                          store_we;

    assign adv       = !(res_valid && res_stall);
    assign pix_stall = !adv;
    assign accept    = pix_valid && adv;
    assign store_we  = adv && s1_valid;

    bf3_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .adv       (adv),
        .accept    (accept),
        .pix_req   (pix_req),
        .rd_addr   (rd_addr),
        .s1_valid  (s1_valid),
        .s1        (s1)
    );

    bf3_ram #(
        .WIDTH (bf3_pkg::PIX_W),
        .DEPTH (bf3_pkg::MAX_LINE)
    ) u_older (
        .clk   (clk),
        .we    (store_we),
        .waddr (s1.idx),
        .wdata (older_wr),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (older_rd)
    );

    bf3_ram #(
        .WIDTH (bf3_pkg::PIX_W),
        .DEPTH (bf3_pkg::MAX_LINE)
    ) u_newer (
        .clk   (clk),
        .we    (store_we),
        .waddr (s1.idx),
        .wdata (s1.pixel),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (newer_rd)
    );

    bf3_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .s1_valid (s1_valid),
        .s1       (s1),
        .older_rd (older_rd),
        .newer_rd (newer_rd),
        .older_wr (older_wr),
        .s2_valid (s2_valid),
        .s2       (s2)
    );

    bf3_mean u_mean (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .s2_valid  (s2_valid),
        .s2        (s2),
        .res_valid (res_valid),
        .res_req   (res_req)
    );

endmodule

[rtl/bf3_checker.sv]
// port level checks for the box filter, bound to the top level
// depends on bf3_pkg and box_filter_3x3
`timescale 1ns / 1ps

module bf3_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              pix_valid,
    input logic              pix_stall,
    input logic              res_valid,
    input logic              res_stall,
    input bf3_pkg::res_req_t res_req
);

    // a stalled result request holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_req))
        else $error("result request changed while stalled");

    // input stalls exactly when the result register is blocked
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall == (res_valid && res_stall))
        else $error("pixel stall does not follow the result register");

    // centre of an interior result never sits on the top row or left column
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_req.out_row != '0 && res_req.out_col != '0)
        else $error("result centre on the frame border");

    // no request while the first stage, sum stage and result register move on drains the pipeline
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(pix_valid, 1) && !$past(pix_stall, 1)
        && !$past(pix_valid, 2) && !$past(pix_stall, 2)
        && !$past(pix_valid, 3) && !$past(pix_stall, 3) |-> !res_valid)
        else $error("result with no pixel request in flight");

endmodule

bind box_filter_3x3 bf3_checker u_bf3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_req   (res_req)
);
